FILE: src/vvfm_pkg.sv
// ============================================================================
// Voxel visible-face mask: shared types and constants
// Field widths, command codes, face bit positions and sequencer codes.
// ============================================================================
package vvfm_pkg;

    // Fixed field widths
    localparam int COORD_W    = 5;
    localparam int MASK_W     = 6;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    // Command carried on the input tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Face bit positions in face_mask
    localparam int FACE_LEFT   = 0;
    localparam int FACE_RIGHT  = 1;
    localparam int FACE_BOTTOM = 2;
    localparam int FACE_TOP    = 3;
    localparam int FACE_BACK   = 4;
    localparam int FACE_FRONT  = 5;

    // Sequencer steps: on a query all but STEP_LAST read a row; data lands a step later
    localparam logic [2:0] STEP_CENTRE = 3'd0;
    localparam logic [2:0] STEP_XM     = 3'd1;
    localparam logic [2:0] STEP_XP     = 3'd2;
    localparam logic [2:0] STEP_YM     = 3'd3;
    localparam logic [2:0] STEP_YP     = 3'd4;
    localparam logic [2:0] STEP_LAST   = 3'd5;

    // Neighbour bits gathered from the x/y rows
    localparam int NB_XM = 0;
    localparam int NB_XP = 1;
    localparam int NB_YM = 2;
    localparam int NB_YP = 3;

    // Control states, one-hot
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

FILE: src/voxel_visible_face_mask_top.sv
// ============================================================================
// Voxel visible-face mask
// Keeps a cubic occupancy map in a row memory (one word per x/y column,
// one bit per z) and answers face-mask queries by reading the centre row
// and its four x/y neighbour rows.
// ============================================================================
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+--------------------------------
//  s       | in  | s_tvalid / s_tready        | s_tdata: x, y, z, occupied
//          |     |                            | s_tuser: command
//  m       | out | m_tvalid / m_tready        | m_tdata: face_mask, cell_solid
//
//  Write: accept, row read, row write back.
//  Query: five row reads through the single read port of the occupancy
//  memory, then the result. An out-of-cube query goes straight to the result;
//  an out-of-cube write is dropped when it is accepted.
//  Reset: a clearing pass writes all 2^(2*clog2(EDGE_SIZE)) rows to empty
//  (1024 at the default size); no beat is accepted meanwhile.
//  A finished result waits in the output register; the next input beat is
//  taken while it waits, and a query stalls at its end until the slot frees.
//
module voxel_visible_face_mask_top #(
    parameter int EDGE_SIZE = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [4:0] coord_x, [9:5] coord_y, [14:10] coord_z, [15] occupied
    input  logic [vvfm_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [5:0] face_mask, [6] cell_solid, [7] zero
    output logic [vvfm_pkg::M_TDATA_W-1:0] m_tdata
);
    import vvfm_pkg::*;

    localparam int CW    = $clog2(EDGE_SIZE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 2 ** AW;
    localparam int CMPW  = COORD_W + $clog2(EDGE_SIZE + 1);
    localparam logic [CMPW-1:0] EDGE_C = CMPW'(EDGE_SIZE);
    localparam logic [CW-1:0]   TOP    = CW'(EDGE_SIZE - 1);

    // Occupancy memory: one row of z bits per (x, y)
    logic [EDGE_SIZE-1:0] mem [DEPTH];
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [EDGE_SIZE-1:0] rd_data_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EDGE_SIZE-1:0] wr_data;

    // Control
    state_t        state_reg, state_next;
    logic [2:0]    step_reg, step_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // Item payload
    logic                 cmd_reg;
    logic                 occ_reg;
    logic                 inside_reg;
    logic [CW-1:0]        x_reg, y_reg, z_reg;
    logic [EDGE_SIZE-1:0] row_c_reg;
    logic [3:0]           nb_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic                 solid_reg;

    // Input field split
    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic               in_occ, in_inside, accept, out_load;
    logic [1:0]         nb_idx;
    logic               solid_c;
    logic [MASK_W-1:0]  mask_c;

    assign in_x   = s_tdata[COORD_W-1:0];
    assign in_y   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_z   = s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_occ = s_tdata[3*COORD_W];
    assign in_inside = (CMPW'(in_x) < EDGE_C) && (CMPW'(in_y) < EDGE_C)
                    && (CMPW'(in_z) < EDGE_C);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign nb_idx   = 2'(step_reg - STEP_XP);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, solid_reg, mask_reg};

    // Row read address per sequencer step
    always_comb
    begin
        case (step_reg)
            STEP_CENTRE: rd_addr = {x_reg, y_reg};
            STEP_XM:     rd_addr = {CW'(x_reg - 1'b1), y_reg};
            STEP_XP:     rd_addr = {CW'(x_reg + 1'b1), y_reg};
            STEP_YM:     rd_addr = {x_reg, CW'(y_reg - 1'b1)};
            STEP_YP:     rd_addr = {x_reg, CW'(y_reg + 1'b1)};
            default:     rd_addr = {x_reg, y_reg};
        endcase
    end

    // Memory port control: clearing pass or row read-modify-write
    always_comb
    begin
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = {x_reg, y_reg};
        wr_data = rd_data_reg;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == ST_READ)
        begin
            if (cmd_reg == CMD_WRITE)
            begin
                rd_en = (step_reg == STEP_CENTRE);
                wr_en = (step_reg == STEP_XM);
                wr_data[z_reg] = occ_reg;
            end
            else
            begin
                rd_en = (step_reg != STEP_LAST);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Face mask from the centre row and the gathered neighbour bits
    always_comb
    begin
        solid_c = inside_reg && row_c_reg[z_reg];
        mask_c  = '0;
        mask_c[FACE_LEFT]   = solid_c && (x_reg != '0) && !nb_reg[NB_XM];
        mask_c[FACE_RIGHT]  = solid_c && (x_reg != TOP) && !nb_reg[NB_XP];
        mask_c[FACE_BOTTOM] = solid_c && (y_reg != '0) && !nb_reg[NB_YM];
        mask_c[FACE_TOP]    = solid_c && (y_reg != TOP) && !nb_reg[NB_YP];
        mask_c[FACE_BACK]   = solid_c && (z_reg != '0)
                           && !row_c_reg[CW'(z_reg - 1'b1)];
        mask_c[FACE_FRONT]  = solid_c && (z_reg != TOP)
                           && !row_c_reg[CW'(z_reg + 1'b1)];
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        clr_addr_next = clr_addr_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = AW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                step_next = STEP_CENTRE;
                if (accept)
                begin
                    if (in_inside)
                    begin
                        state_next = ST_READ;
                    end
                    else if (s_tuser == CMD_QUERY)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_READ:
            begin
                step_next = 3'(step_reg + 1'b1);
                if (cmd_reg == CMD_WRITE && step_reg == STEP_XM)
                begin
                    state_next = ST_IDLE;
                end
                else if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            step_reg     <= STEP_CENTRE;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser;
            occ_reg    <= in_occ;
            inside_reg <= in_inside;
            x_reg      <= CW'(in_x);
            y_reg      <= CW'(in_y);
            z_reg      <= CW'(in_z);
        end
        if (state_reg == ST_READ && cmd_reg == CMD_QUERY)
        begin
            if (step_reg == STEP_XM)
            begin
                row_c_reg <= rd_data_reg;
            end
            else if (step_reg != STEP_CENTRE)
            begin
                nb_reg[nb_idx] <= rd_data_reg[z_reg];
            end
        end
        if (out_load)
        begin
            mask_reg  <= mask_c;
            solid_reg <= solid_c;
        end
    end

    // Checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_no_write_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && cmd_reg == CMD_QUERY) |-> !wr_en)
        else $error("memory written during a query");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FINISH) |-> !wr_en)
        else $error("memory written outside clear or write-back");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !inside_reg) |=> (m_tdata == '0))
        else $error("out-of-cube query gave a non-zero result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_FINISH))
        else $error("finished query left while output slot busy");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// Voxel visible-face mask testbench
// Drives write and query beats into the occupancy map. Each query's face mask
// is predicted from a local copy of the map and checked in order. Directed
// cases come first, then clustered random scenes with random idling on both
// sides, a stretch with no idling, and a long output hold-off.
// ============================================================================
module testbench;

    import vvfm_pkg::*;

    localparam int  EDGE         = 32;
    localparam int  CELLS        = EDGE * EDGE * EDGE;
    localparam time CLK_PERIOD   = 12;
    localparam int  DRAIN_CYCLES = 24;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  IDLE_PERCENT = 26;
    localparam int  MAX_REPORTS  = 10;

    typedef struct packed {
        logic [MASK_W-1:0] face_mask;
        logic              cell_solid;
    } face_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Local copy of the occupancy map, indexed {x, y, z}
    bit             voxel_solid [CELLS];
    face_result_t   pending_faces [$];

    bit src_idle_en;
    bit sink_idle_en;
    int hold_left;
    int mismatches;
    int writes_sent;
    int queries_sent;
    int solid_hits;
    int results_checked;

    voxel_visible_face_mask_top #(
        .EDGE_SIZE (EDGE)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop
    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("timeout: %0d face masks still outstanding", pending_faces.size());
        $display("testbench failed");
        $finish;
    end

    function automatic bit solid_at(input int x, input int y, input int z);
        return voxel_solid[(x * EDGE + y) * EDGE + z];
    endfunction

    // Exposed faces of one voxel; boundary faces are never marked
    function automatic face_result_t predict_faces(input int x, input int y, input int z);
        face_result_t r;
        r = '0;
        if (solid_at(x, y, z))
        begin
            r.cell_solid = 1'b1;
            r.face_mask[FACE_LEFT]   = (x > 0)        && !solid_at(x - 1, y, z);
            r.face_mask[FACE_RIGHT]  = (x < EDGE - 1) && !solid_at(x + 1, y, z);
            r.face_mask[FACE_BOTTOM] = (y > 0)        && !solid_at(x, y - 1, z);
            r.face_mask[FACE_TOP]    = (y < EDGE - 1) && !solid_at(x, y + 1, z);
            r.face_mask[FACE_BACK]   = (z > 0)        && !solid_at(x, y, z - 1);
            r.face_mask[FACE_FRONT]  = (z < EDGE - 1) && !solid_at(x, y, z + 1);
        end
        return r;
    endfunction

    // Send one beat; called and returns at a falling edge
    task automatic send_voxel_beat(input logic cmd, input int x, input int y, input int z,
                                   input logic occ);
        while (src_idle_en && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {occ, z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == CMD_QUERY)
        begin
            pending_faces.push_back(predict_faces(x, y, z));
            queries_sent++;
        end
        else
        begin
            voxel_solid[(x * EDGE + y) * EDGE + z] = occ;
            writes_sent++;
        end
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (sink_idle_en)
                m_tready = ($urandom_range(99) >= IDLE_PERCENT);
            else
                m_tready = 1'b1;
        end
    end

    // Result checker
    always @(posedge clk)
    begin : face_check
        face_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_faces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: mask %b solid %b",
                             m_tdata[MASK_W-1:0], m_tdata[MASK_W]);
            end
            else
            begin
                want = pending_faces.pop_front();
                results_checked++;
                solid_hits += int'(want.cell_solid);
                if (m_tdata[MASK_W-1:0] !== want.face_mask ||
                    m_tdata[MASK_W] !== want.cell_solid)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: mask exp %b got %b, solid exp %b got %b",
                                 results_checked, want.face_mask, m_tdata[MASK_W-1:0],
                                 want.cell_solid, m_tdata[MASK_W]);
                end
            end
        end
    end

    // Coordinate near a cluster base, with some full-range and boundary picks
    function automatic int pick_coord(input int base);
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return $urandom_range(EDGE - 1);
        else if (roll < 20)
            return ($urandom_range(1) != 0) ? EDGE - 1 : 0;
        else
            return base + $urandom_range(3);
    endfunction

    // Random scene: writes and queries packed into small moving clusters
    task automatic run_random_scene(input int count);
        int bx, by, bz;
        logic cmd, occ;
        for (int n = 0; n < count; n++)
        begin
            if (n % 48 == 0)
            begin
                bx = $urandom_range(EDGE - 4);
                by = $urandom_range(EDGE - 4);
                bz = $urandom_range(EDGE - 4);
                if ($urandom_range(3) == 0)
                begin
                    bx = ($urandom_range(1) != 0) ? EDGE - 4 : 0;
                    bz = ($urandom_range(1) != 0) ? EDGE - 4 : 0;
                end
            end
            cmd = ($urandom_range(99) < 55) ? CMD_QUERY : CMD_WRITE;
            occ = ($urandom_range(99) < 65);
            send_voxel_beat(cmd, pick_coord(bx), pick_coord(by), pick_coord(bz), occ);
        end
    endtask

    task automatic test_empty_map();
        // occupied flag is ignored on queries
        send_voxel_beat(CMD_QUERY, 0, 0, 0, 1'b1);
        send_voxel_beat(CMD_QUERY, EDGE - 1, EDGE - 1, EDGE - 1, 1'b0);
    endtask

    task automatic test_single_voxel_faces();
        send_voxel_beat(CMD_WRITE, 10, 10, 10, 1'b1);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b0);
        // cover each face in turn until the voxel is enclosed
        send_voxel_beat(CMD_WRITE,  9, 10, 10, 1'b1);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b0);
        send_voxel_beat(CMD_WRITE, 11, 10, 10, 1'b1);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b0);
        send_voxel_beat(CMD_WRITE, 10,  9, 10, 1'b1);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b0);
        send_voxel_beat(CMD_WRITE, 10, 11, 10, 1'b1);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b0);
        send_voxel_beat(CMD_WRITE, 10, 10,  9, 1'b1);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b0);
        send_voxel_beat(CMD_WRITE, 10, 10, 11, 1'b1);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b0);
        // empty the centre again
        send_voxel_beat(CMD_WRITE, 10, 10, 10, 1'b0);
        send_voxel_beat(CMD_QUERY, 10, 10, 10, 1'b1);
    endtask

    task automatic test_cube_corners();
        send_voxel_beat(CMD_WRITE, 0, 0, 0, 1'b1);
        send_voxel_beat(CMD_QUERY, 0, 0, 0, 1'b0);
        send_voxel_beat(CMD_WRITE, EDGE - 1, EDGE - 1, EDGE - 1, 1'b1);
        send_voxel_beat(CMD_QUERY, EDGE - 1, EDGE - 1, EDGE - 1, 1'b1);
    endtask

    task automatic test_random_with_idling();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        run_random_scene(420);
    endtask

    task automatic test_steady_stream();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random_scene(220);
    endtask

    // Receiver holds off while queries keep coming, so the input stalls
    task automatic test_output_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b1;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        for (int n = 0; n < 40; n++)
            send_voxel_beat(CMD_QUERY, $urandom_range(EDGE - 1), $urandom_range(EDGE - 1),
                            $urandom_range(EDGE - 1), 1'($urandom_range(1)));
        run_random_scene(30);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_WRITE;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_left    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_map();
        test_single_voxel_faces();
        test_cube_corners();
        test_random_with_idling();
        test_steady_stream();
        test_output_backpressure();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        run_random_scene(220);

        // let the last beats drain
        while (pending_faces.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d writes and %0d queries, %0d masks checked (%0d on solid voxels)",
                 writes_sent, queries_sent, results_checked, solid_hits);
        $display("with random idling, an unbroken stream and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_faces.size() == 0)
            $display("testbench passed");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("testbench failed");
        end
        $finish;
    end

endmodule
